// ===== sv/palette_tile_compositor_defines.svh =====
// assertion macros for the palette tile compositor checker
// expects clk and rst_n in the scope where a macro is used
`ifndef PALETTE_TILE_COMPOSITOR_DEFINES_SVH
`define PALETTE_TILE_COMPOSITOR_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define PTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define PTC_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== sv/ptc_pkg.sv =====
// shared types, constants and helper functions for the palette tile compositor
// no dependencies
package ptc_pkg;

    localparam int TILE_DIM_MAX    = 512;
    localparam int FRAME_DIM_MAX   = 4096;
    localparam int PALETTE_ENTRIES = 256;

    // field widths
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int CHAN_W   = 6;
    localparam int PAL_W    = 3 * CHAN_W;
    localparam int COORD_W  = 16;
    localparam int TILE_W   = 10;
    localparam int FRAME_W  = 13;
    localparam int POS_W    = $clog2(FRAME_DIM_MAX);
    localparam int ADDR_W   = 24;
    localparam int ARGB_W   = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [INDEX_W-1:0]   index_t;
    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [PAL_W-1:0]     pal_t;
    typedef logic [TILE_W-1:0]    tile_dim_t;
    typedef logic [FRAME_W-1:0]   frame_dim_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [ARGB_W-1:0]    argb_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // item kinds
    localparam kind_t KIND_PALETTE = 2'd0;
    localparam kind_t KIND_TILE    = 2'd1;
    localparam kind_t KIND_PIXEL   = 2'd2;

    // configuration register indexes
    localparam cfg_idx_t CFG_TILE_WIDTH   = 4'd0;
    localparam cfg_idx_t CFG_TILE_HEIGHT  = 4'd1;
    localparam cfg_idx_t CFG_FRAME_WIDTH  = 4'd2;
    localparam cfg_idx_t CFG_FRAME_HEIGHT = 4'd3;

    // configuration reset values and saturation bounds
    localparam tile_dim_t  TILE_WIDTH_RST   = 10'd384;
    localparam tile_dim_t  TILE_HEIGHT_RST  = 10'd240;
    localparam frame_dim_t FRAME_WIDTH_RST  = 13'd1152;
    localparam frame_dim_t FRAME_HEIGHT_RST = 13'd720;
    localparam tile_dim_t  TILE_CAP         = TILE_W'(TILE_DIM_MAX);
    localparam frame_dim_t FRAME_CAP        = FRAME_W'(FRAME_DIM_MAX);

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // one in-frame pixel on its way to the address stage
    typedef struct packed {
        logic       valid;
        pos_t       x;
        pos_t       y;
        frame_dim_t fw;
    } clip_t;

    // palette memory access issued at item transfer
    typedef struct packed {
        logic   wr_en;
        index_t wr_addr;
        pal_t   wr_data;
        logic   rd_en;
        index_t rd_addr;
    } pal_req_t;

    // 6-bit channel to 8 bits by replicating the top bits
    function automatic logic [7:0] widen6(input chan_t v);
        return {v, v[CHAN_W-1:CHAN_W-2]};
    endfunction

    function automatic argb_t expand_argb(input pal_t e);
        return {ALPHA_OPAQUE, widen6(e[PAL_W-1:2*CHAN_W]),
                widen6(e[2*CHAN_W-1:CHAN_W]), widen6(e[CHAN_W-1:0])};
    endfunction

endpackage

// ===== sv/ptc_if.sv =====
// channel interfaces of the palette tile compositor: items, results, configuration
// depends on ptc_pkg
interface ptc_in_if;
    logic               valid;
    logic               ready;
    ptc_pkg::kind_t     kind;
    ptc_pkg::index_t    entry_index;
    ptc_pkg::chan_t     red;
    ptc_pkg::chan_t     green;
    ptc_pkg::chan_t     blue;
    logic signed [ptc_pkg::COORD_W-1:0] origin_x;
    logic signed [ptc_pkg::COORD_W-1:0] origin_y;
    ptc_pkg::index_t    color_index;

    modport source (output valid, kind, entry_index, red, green, blue,
                    origin_x, origin_y, color_index, input ready);
    modport sink   (input valid, kind, entry_index, red, green, blue,
                    origin_x, origin_y, color_index, output ready);
endinterface

interface ptc_out_if;
    logic           valid;
    logic           ready;
    ptc_pkg::addr_t fb_address;
    ptc_pkg::argb_t argb;

    modport source (output valid, fb_address, argb, input ready);
    modport sink   (input valid, fb_address, argb, output ready);
endinterface

interface ptc_cfg_if;
    logic                            valid;
    logic                            ready;
    ptc_pkg::cfg_idx_t               index;
    logic [ptc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/palette_tile_compositor.sv =====
// Palette tile compositor: indexed tile pixels to clipped ARGB framebuffer writes.
// Channels: items (palette write, tile start, tile pixel), results (fb_address,
// argb), cfg (register index and data for tile and frame dimensions).
// Every channel moves a transfer when valid and ready are both high.
// Throughput: one item per clock; items and cfg writes are always taken while
// the result path flows. Tile pixels outside the frame or past the tile end,
// palette writes, tile starts and items of the unused kind produce no result.
// Stages: a pixel's palette read goes into stage one, the row-times-stride multiply
// into stage two, the address add into the output register.
// A palette write is visible to a pixel taken on the very next edge, since the
// memory write and the later read land on separate edges.
// Stall: when results is held, the three stages fill and items.ready drops only
// when all of them hold a result; empty stages are squeezed out.
// Reset: configuration returns to 384x240 tiles in a 1152x720 frame, the tile
// origin and raster counters clear, the pipeline empties. Palette contents are
// undefined until written.
// depends on ptc_pkg, ptc_if, ptc_ram, ptc_raster and ptc_out
module palette_tile_compositor (
    input  logic      clk,
    input  logic      rst_n,
    ptc_in_if.sink    items,
    ptc_cfg_if.sink   cfg,
    ptc_out_if.source results
);

    ptc_pkg::clip_t    s1;
    ptc_pkg::pal_req_t pal_req;
    ptc_pkg::pal_t     pal_data;
    logic              s2_ready;

    // decode, counters and clipping
    ptc_raster u_raster (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .cfg      (cfg),
        .s2_ready (s2_ready),
        .s1       (s1),
        .pal_req  (pal_req)
    );

    // palette memory
    ptc_ram #(
        .WIDTH (ptc_pkg::PAL_W),
        .DEPTH (ptc_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_req.wr_en),
        .wr_addr (pal_req.wr_addr),
        .wr_data (pal_req.wr_data),
        .rd_en   (pal_req.rd_en),
        .rd_addr (pal_req.rd_addr),
        .rd_data (pal_data)
    );

    // address, colour and result register
    ptc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1       (s1),
        .pal_data (pal_data),
        .s2_ready (s2_ready),
        .results  (results)
    );

endmodule

// ===== sv/ptc_ram.sv =====
// generic single-port-write, single-port-read RAM with registered read data
// no dependencies
module ptc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ptc_raster.sv =====
// item decode, configuration registers, raster counters and frame clipping
// depends on ptc_pkg and ptc_if
module ptc_raster (
    input  logic              clk,
    input  logic              rst_n,
    ptc_in_if.sink            items,
    ptc_cfg_if.sink           cfg,
    input  logic              s2_ready,
    output ptc_pkg::clip_t    s1,
    output ptc_pkg::pal_req_t pal_req
);

    ptc_pkg::tile_dim_t  tile_width_reg, tile_height_reg;
    ptc_pkg::frame_dim_t frame_width_reg, frame_height_reg;
    logic signed [ptc_pkg::COORD_W-1:0] tile_left_reg, tile_left_next;
    logic signed [ptc_pkg::COORD_W-1:0] tile_top_reg, tile_top_next;
    ptc_pkg::tile_dim_t  column_reg, column_next;
    ptc_pkg::tile_dim_t  row_reg, row_next;
    ptc_pkg::clip_t      s1_reg, s1_next;

    ptc_pkg::tile_dim_t  tw, th;
    ptc_pkg::frame_dim_t fw, fh;
    logic [ptc_pkg::COORD_W:0] x_pos, y_pos;
    logic [ptc_pkg::TILE_W:0]  column_inc;
    logic accept, is_pixel, in_tile, x_in, y_in;

    // configuration writes, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg   <= ptc_pkg::TILE_WIDTH_RST;
            tile_height_reg  <= ptc_pkg::TILE_HEIGHT_RST;
            frame_width_reg  <= ptc_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= ptc_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ptc_pkg::CFG_TILE_WIDTH:
                    tile_width_reg <= cfg.data[ptc_pkg::TILE_W-1:0];
                ptc_pkg::CFG_TILE_HEIGHT:
                    tile_height_reg <= cfg.data[ptc_pkg::TILE_W-1:0];
                ptc_pkg::CFG_FRAME_WIDTH:
                    frame_width_reg <= cfg.data[ptc_pkg::FRAME_W-1:0];
                ptc_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg.data[ptc_pkg::FRAME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // saturated dimensions
    always_comb
    begin
        tw = (tile_width_reg > ptc_pkg::TILE_CAP) ? ptc_pkg::TILE_CAP : tile_width_reg;
        th = (tile_height_reg > ptc_pkg::TILE_CAP) ? ptc_pkg::TILE_CAP : tile_height_reg;
        fw = (frame_width_reg > ptc_pkg::FRAME_CAP) ? ptc_pkg::FRAME_CAP : frame_width_reg;
        fh = (frame_height_reg > ptc_pkg::FRAME_CAP) ? ptc_pkg::FRAME_CAP : frame_height_reg;
    end

    // input transfer while stage one is free or draining
    assign items.ready = !s1_reg.valid || s2_ready;
    assign accept      = items.valid && items.ready;
    assign is_pixel    = items.kind == ptc_pkg::KIND_PIXEL;

    // frame position of the current pixel, 17-bit two's complement
    assign x_pos = {tile_left_reg[ptc_pkg::COORD_W-1], tile_left_reg}
                 + {{(ptc_pkg::COORD_W-ptc_pkg::TILE_W+1){1'b0}}, column_reg};
    assign y_pos = {tile_top_reg[ptc_pkg::COORD_W-1], tile_top_reg}
                 + {{(ptc_pkg::COORD_W-ptc_pkg::TILE_W+1){1'b0}}, row_reg};

    // clip against the frame and the tile end
    assign x_in    = !x_pos[ptc_pkg::COORD_W]
                   && (x_pos[ptc_pkg::COORD_W-1:0] < ptc_pkg::COORD_W'(fw));
    assign y_in    = !y_pos[ptc_pkg::COORD_W]
                   && (y_pos[ptc_pkg::COORD_W-1:0] < ptc_pkg::COORD_W'(fh));
    assign in_tile = row_reg < th;
    assign column_inc = {1'b0, column_reg} + 1'b1;

    // tile origin and raster counters
    always_comb
    begin
        tile_left_next = tile_left_reg;
        tile_top_next  = tile_top_reg;
        column_next    = column_reg;
        row_next       = row_reg;
        if (accept)
        begin
            unique case (items.kind)
                ptc_pkg::KIND_TILE:
                begin
                    tile_left_next = items.origin_x;
                    tile_top_next  = items.origin_y;
                    column_next    = '0;
                    row_next       = '0;
                end
                ptc_pkg::KIND_PIXEL:
                begin
                    if (in_tile)
                    begin
                        if (column_inc >= {1'b0, tw})
                        begin
                            column_next = '0;
                            row_next    = row_reg + 1'b1;
                        end
                        else
                        begin
                            column_next = column_inc[ptc_pkg::TILE_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // stage one: in-frame pixel, palette read in flight
    always_comb
    begin
        s1_next = s1_reg;
        if (items.ready)
        begin
            s1_next.valid = accept && is_pixel && in_tile && x_in && y_in;
            s1_next.x     = x_pos[ptc_pkg::POS_W-1:0];
            s1_next.y     = y_pos[ptc_pkg::POS_W-1:0];
            s1_next.fw    = fw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_left_reg <= '0;
            tile_top_reg  <= '0;
            column_reg    <= '0;
            row_reg       <= '0;
            s1_reg        <= '0;
        end
        else
        begin
            tile_left_reg <= tile_left_next;
            tile_top_reg  <= tile_top_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            s1_reg        <= s1_next;
        end
    end

    assign s1 = s1_reg;

    // palette access straight from the transfer
    always_comb
    begin
        pal_req.wr_en   = accept && (items.kind == ptc_pkg::KIND_PALETTE);
        pal_req.wr_addr = items.entry_index;
        pal_req.wr_data = {items.red, items.green, items.blue};
        pal_req.rd_en   = accept && is_pixel;
        pal_req.rd_addr = items.color_index;
    end

endmodule

// ===== sv/ptc_out.sv =====
// address multiply, colour expansion and the result output register
// depends on ptc_pkg and ptc_if
module ptc_out (
    input  logic           clk,
    input  logic           rst_n,
    input  ptc_pkg::clip_t s1,
    input  ptc_pkg::pal_t  pal_data,
    output logic           s2_ready,
    ptc_out_if.source      results
);

    logic           s2_valid_reg, s2_valid_next;
    ptc_pkg::addr_t prod_reg, prod_next;
    ptc_pkg::pos_t  x_reg, x_next;
    ptc_pkg::pal_t  entry_reg, entry_next;
    logic           out_valid_reg, out_valid_next;
    ptc_pkg::addr_t addr_reg, addr_next;
    ptc_pkg::argb_t argb_reg, argb_next;

    logic [ptc_pkg::POS_W+ptc_pkg::FRAME_W-1:0] prod;
    logic adv_out;

    // stall chain, each stage moves when the one after it has room
    assign adv_out  = !out_valid_reg || results.ready;
    assign s2_ready = !s2_valid_reg || adv_out;

    // row times stride
    assign prod = {{ptc_pkg::FRAME_W{1'b0}}, s1.y} * {{ptc_pkg::POS_W{1'b0}}, s1.fw};

    // stage two: product and palette entry
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        prod_next     = prod_reg;
        x_next        = x_reg;
        entry_next    = entry_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1.valid;
            prod_next     = prod[ptc_pkg::ADDR_W-1:0];
            x_next        = s1.x;
            entry_next    = pal_data;
        end
    end

    // output register: address sum and colour
    always_comb
    begin
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        argb_next      = argb_reg;
        if (adv_out)
        begin
            out_valid_next = s2_valid_reg;
            addr_next      = prod_reg + ptc_pkg::ADDR_W'(x_reg);
            argb_next      = ptc_pkg::expand_argb(entry_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        x_reg     <= x_next;
        entry_reg <= entry_next;
        addr_reg  <= addr_next;
        argb_reg  <= argb_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.fb_address = addr_reg;
    assign results.argb       = argb_reg;

endmodule

// ===== sv/ptc_checker.sv =====
// port-level assertions for the palette tile compositor, bound to the top level
// depends on palette_tile_compositor_defines.svh
`include "palette_tile_compositor_defines.svh"

module ptc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_alpha,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // configuration writes never wait
    `PTC_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "cfg write not taken")

    // every result is opaque
    `PTC_ASSERT(a_alpha, out_valid |-> (out_alpha == 8'hFF), "alpha not opaque")

    // items back up only behind a full, stalled result path
    `PTC_ASSERT(a_in_stall, !in_ready |-> (out_valid && !out_ready),
        "items stalled while result path has room")

    // a stalled result stays offered
    `PTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
        "result dropped while stalled")

endmodule

bind palette_tile_compositor ptc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_alpha (results.argb[31:24]),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

// ===== tb/tb_palette_tile_compositor.sv =====
// self-checking testbench for palette_tile_compositor: directed rows, then random phases
// under several tile and frame settings, every framebuffer write checked against a listed or predicted one
// depends on ptc_pkg, ptc_if (ptc_in_if, ptc_out_if, ptc_cfg_if) and the compositor rtl
module tb_palette_tile_compositor;
    import ptc_pkg::*;

    localparam kind_t KIND_UNUSED     = 2'd3;
    localparam int    NUM_PHASES      = 14;
    localparam int    ITEMS_PER_PHASE = 56;
    localparam int    SETTLE_CYCLES   = 8;
    localparam int    TIMEOUT_TU      = 8000000;

    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_RESULT} check_t;

    typedef struct {
        kind_t              kind;
        index_t             entry_index;
        chan_t              red;
        chan_t              green;
        chan_t              blue;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        index_t             color_index;
    } item_t;

    typedef struct {
        item_t  it;
        check_t chk;
        addr_t  fb_address;
        argb_t  argb;
    } row_t;

    typedef struct packed {
        addr_t fb_address;
        argb_t argb;
    } fb_write_t;

    logic clk = 1'b0;
    logic rst_n;

    ptc_in_if  items_if ();
    ptc_cfg_if cfg_if ();
    ptc_out_if results_if ();

    palette_tile_compositor u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .cfg     (cfg_if),
        .results (results_if)
    );

    // predictor state: configuration, palette, tile origin and raster position
    tile_dim_t          tile_width_r  = TILE_WIDTH_RST;
    tile_dim_t          tile_height_r = TILE_HEIGHT_RST;
    frame_dim_t         frame_width_r = FRAME_WIDTH_RST;
    frame_dim_t         frame_height_r = FRAME_HEIGHT_RST;
    pal_t               palette_mem [PALETTE_ENTRIES];
    bit                 loaded [PALETTE_ENTRIES];
    index_t             loaded_entries [$];
    logic signed [15:0] tile_left = '0;
    logic signed [15:0] tile_top  = '0;
    int                 column_count = 0;
    int                 row_count    = 0;

    fb_write_t pending_writes [$];
    int        mismatches = 0;
    int        tx_calm = 0;
    int        rx_calm = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // random wait before a transfer, with occasional runs of back-to-back transfers
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic int tile_cap(input int v);
        return (v > TILE_DIM_MAX) ? TILE_DIM_MAX : v;
    endfunction

    function automatic int frame_cap(input int v);
        return (v > FRAME_DIM_MAX) ? FRAME_DIM_MAX : v;
    endfunction

    // 6-bit channel widened to 8 bits, top bits repeated at the bottom
    function automatic logic [7:0] chan8(input chan_t v);
        logic [7:0] w;
        w = {2'b00, v};
        return (w << 2) | (w >> 4);
    endfunction

    // applies one item to the predictor state; returns 1 when a framebuffer write results
    function automatic bit blit_item(input item_t it, output fb_write_t wr);
        int   tw;
        int   th;
        int   fw;
        int   fh;
        int   x;
        int   y;
        pal_t e;
        wr = '0;
        case (it.kind)
            KIND_PALETTE:
            begin
                palette_mem[it.entry_index] = {it.red, it.green, it.blue};
                if (!loaded[it.entry_index])
                begin
                    loaded[it.entry_index] = 1'b1;
                    loaded_entries.push_back(it.entry_index);
                end
                return 1'b0;
            end
            KIND_TILE:
            begin
                tile_left    = it.origin_x;
                tile_top     = it.origin_y;
                column_count = 0;
                row_count    = 0;
                return 1'b0;
            end
            KIND_PIXEL:
            begin
                tw = tile_cap(tile_width_r);
                th = tile_cap(tile_height_r);
                fw = frame_cap(frame_width_r);
                fh = frame_cap(frame_height_r);
                // past the tile end: dropped, counters hold
                if (row_count >= th)
                    return 1'b0;
                x = int'(tile_left) + column_count;
                y = int'(tile_top) + row_count;
                e = palette_mem[it.color_index];
                wr.argb = {8'hFF, chan8(e[17:12]), chan8(e[11:6]), chan8(e[5:0])};
                wr.fb_address = addr_t'(y * fw + x);
                if (column_count + 1 >= tw)
                begin
                    column_count = 0;
                    row_count++;
                end
                else
                begin
                    column_count++;
                end
                return (x >= 0 && y >= 0 && x < fw && y < fh);
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic row_t pal_row(input index_t e, input chan_t r, input chan_t g,
                                     input chan_t b);
        row_t row;
        row = '{it: '{default: '0}, chk: CHK_NONE, fb_address: '0, argb: '0};
        row.it.kind        = KIND_PALETTE;
        row.it.entry_index = e;
        row.it.red         = r;
        row.it.green       = g;
        row.it.blue        = b;
        return row;
    endfunction

    function automatic row_t tile_row(input logic signed [15:0] ox,
                                      input logic signed [15:0] oy);
        row_t row;
        row = '{it: '{default: '0}, chk: CHK_NONE, fb_address: '0, argb: '0};
        row.it.kind     = KIND_TILE;
        row.it.origin_x = ox;
        row.it.origin_y = oy;
        return row;
    endfunction

    function automatic row_t pix_row(input index_t ci, input check_t chk, input addr_t a,
                                     input argb_t c);
        row_t row;
        row = '{it: '{default: '0}, chk: chk, fb_address: a, argb: c};
        row.it.kind        = KIND_PIXEL;
        row.it.color_index = ci;
        return row;
    endfunction

    // random item: mostly pixels of loaded entries, with palette writes, tile starts and noise
    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    tw;
        int    th;
        it.kind        = KIND_PIXEL;
        it.entry_index = index_t'($urandom);
        it.red         = chan_t'($urandom);
        it.green       = chan_t'($urandom);
        it.blue        = chan_t'($urandom);
        it.origin_x    = 16'($urandom);
        it.origin_y    = 16'($urandom);
        it.color_index = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
        tw = tile_cap(tile_width_r);
        th = tile_cap(tile_height_r);
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            it.kind = KIND_PALETTE;
        end
        else if (pick < 26)
        begin
            it.kind = KIND_TILE;
            // most tiles land across the frame, the rest anywhere in the coordinate range
            if ($urandom_range(0, 4) != 0)
            begin
                it.origin_x = 16'(int'($urandom_range(0, frame_cap(frame_width_r) + tw + 4))
                                  - tw - 2);
                it.origin_y = 16'(int'($urandom_range(0, frame_cap(frame_height_r) + th + 4))
                                  - th - 2);
            end
        end
        else if (pick < 29)
        begin
            it.kind        = KIND_UNUSED;
            it.color_index = index_t'($urandom);
        end
        return it;
    endfunction

    // one item transfer, then prediction of its framebuffer write
    task automatic send_item(input row_t row);
        int        gap;
        fb_write_t wr;
        bit        hit;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            items_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_if.valid       <= 1'b1;
        items_if.kind        <= row.it.kind;
        items_if.entry_index <= row.it.entry_index;
        items_if.red         <= row.it.red;
        items_if.green       <= row.it.green;
        items_if.blue        <= row.it.blue;
        items_if.origin_x    <= row.it.origin_x;
        items_if.origin_y    <= row.it.origin_y;
        items_if.color_index <= row.it.color_index;
        do @(posedge clk); while (!items_if.ready);
        hit = blit_item(row.it, wr);
        if (row.chk == CHK_RESULT)
            pending_writes.push_back('{row.fb_address, row.argb});
        else if (row.chk == CHK_PREDICT && hit)
            pending_writes.push_back(wr);
    endtask

    // register write; valid stays high so back-to-back writes follow without a gap
    task automatic write_reg(input cfg_idx_t idx, input int value, input int width,
                             input bit noisy);
        logic [CFG_DATA_W-1:0] data;
        logic [CFG_DATA_W-1:0] keep;
        keep = (CFG_DATA_W'(1) << width) - 1'b1;
        data = CFG_DATA_W'(value) & keep;
        if (noisy)
            data = data | (CFG_DATA_W'($urandom) & ~keep);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            CFG_TILE_WIDTH:   tile_width_r   = data[TILE_W-1:0];
            CFG_TILE_HEIGHT:  tile_height_r  = data[TILE_W-1:0];
            CFG_FRAME_WIDTH:  frame_width_r  = data[FRAME_W-1:0];
            CFG_FRAME_HEIGHT: frame_height_r = data[FRAME_W-1:0];
            default: ;
        endcase
    endtask

    // all expected writes delivered, then let items with no result leave the pipeline
    task automatic wait_idle();
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls, each transfer checked against the oldest expectation
    initial
    begin : result_sink
        int        gap;
        fb_write_t want;
        results_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(rx_calm);
            if (gap > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do @(posedge clk); while (!results_if.valid);
            if (pending_writes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected write: expected none, actual addr %h argb %h",
                         $time, results_if.fb_address, results_if.argb);
            end
            else
            begin
                want = pending_writes.pop_front();
                if (results_if.fb_address !== want.fb_address)
                begin
                    mismatches++;
                    $display("%0t: fb_address mismatch: expected %h actual %h",
                             $time, want.fb_address, results_if.fb_address);
                end
                if (results_if.argb !== want.argb)
                begin
                    mismatches++;
                    $display("%0t: argb mismatch: expected %h actual %h",
                             $time, want.argb, results_if.argb);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #(TIMEOUT_TU);
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        row_t directed [$];
        row_t row;
        int   tw;
        int   th;
        int   fw;
        int   fh;
        bit   noisy;

        items_if.valid       <= 1'b0;
        items_if.kind        <= KIND_PALETTE;
        items_if.entry_index <= '0;
        items_if.red         <= '0;
        items_if.green       <= '0;
        items_if.blue        <= '0;
        items_if.origin_x    <= '0;
        items_if.origin_y    <= '0;
        items_if.color_index <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= CFG_TILE_WIDTH;
        cfg_if.data          <= '0;
        rst_n                <= 1'b0;
        foreach (palette_mem[i])
        begin
            palette_mem[i] = '0;
            loaded[i]      = 1'b0;
        end

        // directed rows at the reset configuration: 384x240 tiles in a 1152x720 frame
        directed.push_back(pal_row(8'd0, 6'd0, 6'd0, 6'd0));
        directed.push_back(pal_row(8'd255, 6'd63, 6'd63, 6'd63));
        directed.push_back(pal_row(8'd1, 6'd63, 6'd0, 6'd0));
        directed.push_back(pal_row(8'd2, 6'd0, 6'd63, 6'd0));
        directed.push_back(pal_row(8'd3, 6'd0, 6'd0, 6'd63));
        // raster starts at the origin after reset
        directed.push_back(pix_row(8'd255, CHK_RESULT, 24'd0, 32'hFFFF_FFFF));
        directed.push_back(pix_row(8'd0, CHK_RESULT, 24'd1, 32'hFF00_0000));
        directed.push_back(pix_row(8'd1, CHK_RESULT, 24'd2, 32'hFFFF_0000));
        directed.push_back(pix_row(8'd2, CHK_RESULT, 24'd3, 32'hFF00_FF00));
        directed.push_back(pix_row(8'd3, CHK_RESULT, 24'd4, 32'hFF00_00FF));
        // unused kind is ignored
        row = pix_row(8'd255, CHK_NONE, '0, '0);
        row.it.kind     = KIND_UNUSED;
        row.it.origin_x = -16'sd1;
        directed.push_back(row);
        // tile above and left of the frame: clipped
        directed.push_back(tile_row(-16'sd1, -16'sd1));
        directed.push_back(pix_row(8'd255, CHK_NONE, '0, '0));
        directed.push_back(pix_row(8'd0, CHK_NONE, '0, '0));
        // last pixel of the frame, then one past the right edge
        directed.push_back(tile_row(16'sd1151, 16'sd719));
        directed.push_back(pix_row(8'd255, CHK_RESULT, 24'd829439, 32'hFFFF_FFFF));
        directed.push_back(pix_row(8'd255, CHK_NONE, '0, '0));
        // coordinate extremes
        directed.push_back(tile_row(16'sh7FFF, 16'sh7FFF));
        directed.push_back(pix_row(8'd1, CHK_NONE, '0, '0));
        directed.push_back(tile_row(-16'sh8000, -16'sh8000));
        directed.push_back(pix_row(8'd2, CHK_NONE, '0, '0));
        directed.push_back(tile_row(16'sd5, 16'sd6));
        directed.push_back(pix_row(8'd1, CHK_PREDICT, '0, '0));
        directed.push_back(pal_row(8'h80, 6'h2A, 6'h15, 6'h3F));
        directed.push_back(pix_row(8'h80, CHK_PREDICT, '0, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i]);
        items_if.valid <= 1'b0;

        // random phases, each under its own tile and frame setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            noisy = 1'b0;
            case (p)
                0: begin tw = 4;    th = 3;    fw = 16;   fh = 12;   end
                1: begin tw = 1;    th = 1;    fw = 1;    fh = 1;    end
                2: begin tw = 512;  th = 512;  fw = 4096; fh = 4096; end
                3: begin tw = 1023; th = 1023; fw = 8191; fh = 8191; end
                4: begin tw = 0;    th = 3;    fw = 8;    fh = 8;    end
                5: begin tw = 5;    th = 0;    fw = 8;    fh = 8;    end
                6: begin tw = 3;    th = 3;    fw = 0;    fh = 6;    end
                7: begin tw = 3;    th = 3;    fw = 6;    fh = 0;    end
                default:
                begin
                    noisy = ($urandom_range(0, 2) == 0);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        tw = $urandom_range(1, 8);
                        th = $urandom_range(1, 6);
                        fw = $urandom_range(1, 24);
                        fh = $urandom_range(1, 24);
                    end
                    else
                    begin
                        tw = $urandom_range(1, 40);
                        th = $urandom_range(1, 20);
                        fw = $urandom_range(1, 200);
                        fh = $urandom_range(1, 200);
                    end
                end
            endcase

            wait_idle();
            write_reg(CFG_TILE_WIDTH, tw, TILE_W, noisy);
            write_reg(CFG_TILE_HEIGHT, th, TILE_W, noisy);
            write_reg(CFG_FRAME_WIDTH, fw, FRAME_W, noisy);
            write_reg(CFG_FRAME_HEIGHT, fh, FRAME_W, noisy);
            cfg_if.valid <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                row.it         = random_item();
                row.chk        = CHK_PREDICT;
                row.fb_address = '0;
                row.argb       = '0;
                send_item(row);
            end
            items_if.valid <= 1'b0;
        end

        wait_idle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== palette_tile_compositor.f =====
+incdir+sv
sv/ptc_pkg.sv
sv/ptc_if.sv
sv/ptc_ram.sv
sv/ptc_raster.sv
sv/ptc_out.sv
sv/palette_tile_compositor.sv
sv/ptc_checker.sv
tb/tb_palette_tile_compositor.sv
